[src/cle_pkg.sv]
package cle_pkg;

  localparam int LEN_W      = 6;
  localparam int STEP_W     = 4;
  localparam int TABLE_SIZE = 14;
  localparam int NAME_W     = 16;

  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_PROMPT = 8'd62;

  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_CMD = 2'd1;
  localparam logic [1:0] KIND_ARG = 2'd2;

  // names are right-justified in the packed word, first char in the highest byte of the name
  localparam logic [8*NAME_W-1:0] NAME_TEXT [TABLE_SIZE] = '{
    "flush", "print", "lab1results", "lab2results", "lab3results", "lab4results",
    "robot", "dir", "delete", "type", "format", "jitter", "dft", "?"
  };
  localparam int NAME_LEN [TABLE_SIZE] = '{5, 5, 11, 11, 11, 11, 5, 3, 6, 4, 6, 6, 3, 1};

  function automatic logic [7:0] name_char(input int idx, input logic [LEN_W-1:0] pos);
    int p;
    p = int'(pos);
    if (p >= NAME_LEN[idx]) begin
      return 8'd0;
    end
    return NAME_TEXT[idx][8*(NAME_LEN[idx]-1-p) +: 8];
  endfunction

  // microprogram step addresses
  localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] ST_TEST_EOL = 4'd1;
  localparam logic [STEP_W-1:0] ST_TEST_ERS = 4'd2;
  localparam logic [STEP_W-1:0] ST_TEST_FUL = 4'd3;
  localparam logic [STEP_W-1:0] ST_STORE    = 4'd4;
  localparam logic [STEP_W-1:0] ST_ERASE    = 4'd5;
  localparam logic [STEP_W-1:0] ST_ERS_BS0  = 4'd6;
  localparam logic [STEP_W-1:0] ST_ERS_SP   = 4'd7;
  localparam logic [STEP_W-1:0] ST_ERS_BS1  = 4'd8;
  localparam logic [STEP_W-1:0] ST_EOL      = 4'd9;
  localparam logic [STEP_W-1:0] ST_EOL_LF   = 4'd10;
  localparam logic [STEP_W-1:0] ST_SCAN     = 4'd11;
  localparam logic [STEP_W-1:0] ST_MATCH    = 4'd12;
  localparam logic [STEP_W-1:0] ST_CMD      = 4'd13;
  localparam logic [STEP_W-1:0] ST_ARG      = 4'd14;
  localparam logic [STEP_W-1:0] ST_PROMPT   = 4'd15;

  typedef enum logic [2:0] {
    E_NONE, E_ECHO, E_BS, E_SP, E_LF, E_CMD, E_ARG, E_PROMPT
  } emit_t;

  typedef enum logic [2:0] {
    A_NONE, A_ACCEPT, A_STORE, A_LEN_DEC, A_SCAN, A_MATCH, A_PTR_INC, A_FINISH
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_IN, C_EOL, C_ERASE, C_FULL, C_EMPTY,
    C_TOK_MORE, C_NO_ARGS, C_ARG_MORE
  } cond_t;

  typedef enum logic [1:0] {
    G_ALWAYS, G_TAKEN, G_NOT_TAKEN
  } gate_t;

  typedef struct packed {
    emit_t             emit;
    logic              last;
    act_t              act;
    gate_t             gate;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic no_in;
    logic eol;
    logic erase;
    logic full;
    logic empty;
    logic tok_more;
    logic no_args;
    logic arg_more;
  } cond_flags_t;

  typedef struct packed {
    emit_t emit;
    logic  last;
    act_t  act;
    logic  fire;
    logic  idle;
  } ctrl_t;

endpackage

[src/cle_if.sv]
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface cle_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [3:0]  command_id;
  logic        has_args;
  logic [15:0] line_number;
  logic        last;

  modport source(output valid, output kind, output out_byte, output command_id,
                 output has_args, output line_number, output last, input ready);
  modport sink(input valid, input kind, input out_byte, input command_id,
               input has_args, input line_number, input last, output ready);
endinterface

[src/cle_seq.sv]
module cle_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  cle_pkg::cond_flags_t flags,
  input  logic                 out_busy,
  output cle_pkg::ctrl_t       ctrl
);

  function automatic cle_pkg::uword_t ucode(input logic [cle_pkg::STEP_W-1:0] s);
    cle_pkg::uword_t w;
    w = '{emit: cle_pkg::E_NONE, last: 1'b0, act: cle_pkg::A_NONE,
          gate: cle_pkg::G_ALWAYS, cond: cle_pkg::C_NEVER, target: cle_pkg::ST_IDLE};
    case (s)
      cle_pkg::ST_IDLE: begin
        w.cond = cle_pkg::C_NO_IN; w.target = cle_pkg::ST_IDLE;
        w.act = cle_pkg::A_ACCEPT; w.gate = cle_pkg::G_NOT_TAKEN;
      end
      cle_pkg::ST_TEST_EOL: begin
        w.cond = cle_pkg::C_EOL; w.target = cle_pkg::ST_EOL;
      end
      cle_pkg::ST_TEST_ERS: begin
        w.cond = cle_pkg::C_ERASE; w.target = cle_pkg::ST_ERASE;
      end
      cle_pkg::ST_TEST_FUL: begin
        w.cond = cle_pkg::C_FULL; w.target = cle_pkg::ST_IDLE;
      end
      cle_pkg::ST_STORE: begin
        w.emit = cle_pkg::E_ECHO; w.last = 1'b1; w.act = cle_pkg::A_STORE;
        w.cond = cle_pkg::C_ALWAYS; w.target = cle_pkg::ST_IDLE;
      end
      cle_pkg::ST_ERASE: begin
        w.cond = cle_pkg::C_EMPTY; w.target = cle_pkg::ST_IDLE;
      end
      cle_pkg::ST_ERS_BS0: begin
        w.emit = cle_pkg::E_BS; w.act = cle_pkg::A_LEN_DEC;
      end
      cle_pkg::ST_ERS_SP: begin
        w.emit = cle_pkg::E_SP;
      end
      cle_pkg::ST_ERS_BS1: begin
        w.emit = cle_pkg::E_BS; w.last = 1'b1;
        w.cond = cle_pkg::C_ALWAYS; w.target = cle_pkg::ST_IDLE;
      end
      cle_pkg::ST_EOL: begin
        w.cond = cle_pkg::C_EMPTY; w.target = cle_pkg::ST_IDLE;
      end
      cle_pkg::ST_EOL_LF: begin
        w.emit = cle_pkg::E_LF;
      end
      cle_pkg::ST_SCAN: begin
        w.cond = cle_pkg::C_TOK_MORE; w.target = cle_pkg::ST_SCAN;
        w.act = cle_pkg::A_SCAN; w.gate = cle_pkg::G_TAKEN;
      end
      cle_pkg::ST_MATCH: begin
        w.act = cle_pkg::A_MATCH;
      end
      cle_pkg::ST_CMD: begin
        w.emit = cle_pkg::E_CMD;
        w.cond = cle_pkg::C_NO_ARGS; w.target = cle_pkg::ST_PROMPT;
      end
      cle_pkg::ST_ARG: begin
        w.emit = cle_pkg::E_ARG; w.act = cle_pkg::A_PTR_INC; w.gate = cle_pkg::G_TAKEN;
        w.cond = cle_pkg::C_ARG_MORE; w.target = cle_pkg::ST_ARG;
      end
      cle_pkg::ST_PROMPT: begin
        w.emit = cle_pkg::E_PROMPT; w.last = 1'b1; w.act = cle_pkg::A_FINISH;
        w.cond = cle_pkg::C_ALWAYS; w.target = cle_pkg::ST_IDLE;
      end
      default: begin
        w.cond = cle_pkg::C_ALWAYS; w.target = cle_pkg::ST_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [cle_pkg::STEP_W-1:0] step;
  logic [cle_pkg::STEP_W-1:0] step_next;
  cle_pkg::uword_t            word;
  logic                       taken;
  logic                       fire_raw;
  logic                       stall;

  always_comb begin
    word = ucode(step);
    case (word.cond)
      cle_pkg::C_NEVER:    taken = 1'b0;
      cle_pkg::C_ALWAYS:   taken = 1'b1;
      cle_pkg::C_NO_IN:    taken = flags.no_in;
      cle_pkg::C_EOL:      taken = flags.eol;
      cle_pkg::C_ERASE:    taken = flags.erase;
      cle_pkg::C_FULL:     taken = flags.full;
      cle_pkg::C_EMPTY:    taken = flags.empty;
      cle_pkg::C_TOK_MORE: taken = flags.tok_more;
      cle_pkg::C_NO_ARGS:  taken = flags.no_args;
      cle_pkg::C_ARG_MORE: taken = flags.arg_more;
      default:             taken = 1'b0;
    endcase
    case (word.gate)
      cle_pkg::G_TAKEN:     fire_raw = taken;
      cle_pkg::G_NOT_TAKEN: fire_raw = !taken;
      default:              fire_raw = 1'b1;
    endcase
    // a step that emits waits for the output register to free up
    stall = fire_raw && (word.emit != cle_pkg::E_NONE) && out_busy;
    if (stall) begin
      step_next = step;
    end else if (taken) begin
      step_next = word.target;
    end else begin
      step_next = step + 1'b1;
    end
    ctrl.emit = word.emit;
    ctrl.last = word.last;
    ctrl.act  = word.act;
    ctrl.fire = fire_raw && !stall;
    ctrl.idle = (step == cle_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= cle_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[src/command_line_editor_matcher.sv]
// Channel   Modport          Payload
// bytes     cle_in_if.sink   rx_byte[7:0]
// results   cle_out_if.source kind, out_byte, command_id, has_args, line_number, last
//
// One byte in work at a time. End of line scans the token in the line buffer and,
// when a space ends the token, walks the argument bytes; the line buffer has one
// read port, walked one byte per cycle unless the output register holds a result.
// Reset (rst, synchronous): empty line, line counter 3, no result pending.
// A result held in the output register stalls only steps that emit.
module command_line_editor_matcher #(
  parameter int LINE_MAX  = 49,
  parameter int NUM_NAMES = 14,
  parameter int NAME_MAX  = 11
) (
  input  logic             clk,
  input  logic             rst,
  cle_in_if.sink           bytes,
  cle_out_if.source        results
);

  localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  cle_pkg::ctrl_t       ctrl;
  cle_pkg::cond_flags_t flags;

  logic [7:0]                    line_store [LINE_MAX];
  logic [cle_pkg::LEN_W-1:0]     len;
  logic [15:0]                   line_counter;
  logic [cle_pkg::LEN_W-1:0]     ptr;
  logic [cle_pkg::LEN_W-1:0]     ptr_next;
  logic [7:0]                    rx;
  logic [7:0]                    rdata;
  logic                          args;
  logic [3:0]                    cmd;
  logic [cle_pkg::TABLE_SIZE-1:0] alive;
  logic [cle_pkg::TABLE_SIZE-1:0] alive_init;
  logic [cle_pkg::TABLE_SIZE-1:0] alive_scan;
  logic [3:0]                    cmd_hit;
  logic                          out_busy;
  logic                          out_valid;
  logic                          load;

  assign out_busy = out_valid && !results.ready;

  cle_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  assign bytes.ready = ctrl.idle;

  always_comb begin
    flags.no_in    = !bytes.valid;
    flags.eol      = (rx == cle_pkg::CH_CR) || (rx == cle_pkg::CH_LF);
    flags.erase    = (rx == cle_pkg::CH_DEL) || (rx == cle_pkg::CH_BS);
    flags.full     = (len >= cle_pkg::LEN_W'(LINE_MAX));
    flags.empty    = (len == '0);
    flags.tok_more = (ptr != len) && (rdata != 8'd0) && (rdata != cle_pkg::CH_SPACE);
    flags.no_args  = !args;
    flags.arg_more = (ptr != len) && (rdata != 8'd0);
  end

  // name matching runs alongside the token scan, all table entries at once
  always_comb begin
    int  nl;
    logic found;
    found   = 1'b0;
    cmd_hit = 4'(NUM_NAMES);
    for (int i = 0; i < cle_pkg::TABLE_SIZE; i++) begin
      nl = (cle_pkg::NAME_LEN[i] > NAME_MAX) ? NAME_MAX : cle_pkg::NAME_LEN[i];
      alive_init[i] = (i < NUM_NAMES);
      alive_scan[i] = alive[i] && (ptr < cle_pkg::LEN_W'(nl))
                      && (rdata == cle_pkg::name_char(i, ptr));
      if (!found && alive[i] && (ptr == cle_pkg::LEN_W'(nl))) begin
        found   = 1'b1;
        cmd_hit = 4'(i);
      end
    end
  end

  always_comb begin
    ptr_next = ptr;
    if (ctrl.fire) begin
      case (ctrl.act)
        cle_pkg::A_ACCEPT:  ptr_next = '0;
        cle_pkg::A_SCAN,
        cle_pkg::A_MATCH,
        cle_pkg::A_PTR_INC: ptr_next = ptr + 1'b1;
        default:            ptr_next = ptr;
      endcase
    end
  end

  // read at the next pointer so rdata tracks line_store[ptr]
  always_ff @(posedge clk) begin
    if (ctrl.fire && (ctrl.act == cle_pkg::A_STORE)) begin
      line_store[len[ADDR_W-1:0]] <= rx;
    end
    rdata <= line_store[ptr_next[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      line_counter <= 16'd3;
      ptr          <= '0;
    end else begin
      ptr <= ptr_next;
      if (ctrl.fire) begin
        case (ctrl.act)
          cle_pkg::A_STORE:   len <= len + 1'b1;
          cle_pkg::A_LEN_DEC: len <= len - 1'b1;
          cle_pkg::A_FINISH: begin
            len          <= '0;
            line_counter <= line_counter + 16'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.act)
        cle_pkg::A_ACCEPT: begin
          rx    <= bytes.rx_byte;
          alive <= alive_init;
          args  <= 1'b0;
        end
        cle_pkg::A_SCAN: alive <= alive_scan;
        cle_pkg::A_MATCH: begin
          cmd  <= cmd_hit;
          args <= (ptr != len) && (rdata == cle_pkg::CH_SPACE);
        end
        default: ;
      endcase
    end
  end

  assign load = ctrl.fire && (ctrl.emit != cle_pkg::E_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.kind        <= cle_pkg::KIND_TX;
      results.command_id  <= 4'd0;
      results.has_args    <= 1'b0;
      results.line_number <= 16'd0;
      results.last        <= ctrl.last;
      case (ctrl.emit)
        cle_pkg::E_ECHO:   results.out_byte <= rx;
        cle_pkg::E_BS:     results.out_byte <= cle_pkg::CH_BS;
        cle_pkg::E_SP:     results.out_byte <= cle_pkg::CH_SPACE;
        cle_pkg::E_LF:     results.out_byte <= cle_pkg::CH_LF;
        cle_pkg::E_PROMPT: results.out_byte <= cle_pkg::CH_PROMPT;
        cle_pkg::E_CMD: begin
          results.kind        <= cle_pkg::KIND_CMD;
          results.out_byte    <= 8'd0;
          results.command_id  <= cmd;
          results.has_args    <= args;
          results.line_number <= line_counter;
        end
        cle_pkg::E_ARG: begin
          results.kind     <= cle_pkg::KIND_ARG;
          results.out_byte <= rdata;
        end
        default: results.out_byte <= 8'd0;
      endcase
    end
  end

  assign results.valid = out_valid;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= cle_pkg::LEN_W'(LINE_MAX))
    else $error("line length beyond buffer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (bytes.valid && bytes.ready) |=> !bytes.ready)
    else $error("byte taken while previous one still in work");

  a_cmd_line: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.kind == cle_pkg::KIND_CMD))
      |-> (results.line_number == line_counter))
    else $error("line counter moved before command transfer");

endmodule
